// ===== src/particle_energy_enstrophy_sum_core_assert.svh =====
// Assertion macros for the checker file of the particle energy core.
`ifndef PARTICLE_ENERGY_ENSTROPHY_SUM_CORE_ASSERT_SVH
`define PARTICLE_ENERGY_ENSTROPHY_SUM_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PEES_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PEES_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== src/pees_pkg.sv =====
// ----------------------------------------------------------------------------
// pees_pkg
// Widths and shared types for the particle energy and enstrophy core.
// ----------------------------------------------------------------------------
package pees_pkg;
  localparam int FracBits = 16;
  localparam int InW      = 32;
  localparam int SqW      = 64;   // sum of three squares fits 64 bits
  localparam int CubeW    = 96;   // s cubed
  localparam int ProdW    = SqW + CubeW;
  localparam int NumW     = SqW + FracBits + 32;
  localparam int QuoW     = NumW;
  localparam int OutW     = 64;
  localparam int EShift   = 5 * FracBits - 31;
  localparam int CntW     = 8;

  // Control bundle from the sequencer to the serial multiplier.
  typedef struct packed {
    logic start;
    logic busy;
  } pees_ctl_t;

  // Magnitude of a signed 32-bit value, 2^31 exact.
  function automatic logic [InW-1:0] mag32(input logic [InW-1:0] v);
    mag32 = v[InW-1] ? (~v + 1'b1) : v;
  endfunction
endpackage

// ===== src/particle_energy_enstrophy_sum_core.sv =====
// ----------------------------------------------------------------------------
// particle_energy_enstrophy_sum_core
// Sums kinetic energy and enstrophy of vortex particles, saturating.
// ----------------------------------------------------------------------------
// Per word: three passes of the bit-serial multiplier (s squared, s cubed,
// energy product), then the divider, which is skipped when the core size is zero.
// A new word is taken only once the last one is through and no result waits
// in the output register.
// Reset: synchronous; clears both totals, the flag and the output valid.
module particle_energy_enstrophy_sum_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] vel_x,
  input  logic [31:0] vel_y,
  input  logic [31:0] vel_z,
  input  logic [31:0] vort_x,
  input  logic [31:0] vort_y,
  input  logic [31:0] vort_z,
  input  logic [31:0] core_size,
  input  logic        last_particle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] kinetic_energy,
  output logic [63:0] enstrophy,
  output logic        saturated
);
  import pees_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SQ, S_CUBE, S_EN, S_DIV, S_ACC} state_t;
  state_t state;

  logic [SqW-1:0]   usq, gsq;
  logic [CubeW-1:0] cube;
  logic [InW-1:0]   s_reg;
  logic             last_reg;
  logic [OutW-1:0]  energy_sum, enstrophy_sum, eterm;
  logic             overflow_seen, term_sat;
  pees_ctl_t        mctl;
  logic             mstart;
  logic [SqW-1:0]   mul_a;
  logic [CubeW-1:0] mul_b;
  logic [ProdW-1:0] prod, eshift;
  logic             mdone, dstart, ddone, dovf;
  logic [OutW-1:0]  dquo;
  logic [64:0]      esum_w;
  logic [InW-1:0]   mvx, mvy, mvz, mgx, mgy, mgz;
  logic [1:0]       sq_phase;
  logic [InW-1:0]   hy, hz, ky, kz;
  logic [InW-1:0]   u_op, g_op;
  logic [SqW-1:0]   u_sq, g_sq;

  assign mvx = mag32(vel_x);
  assign mvy = mag32(vel_y);
  assign mvz = mag32(vel_z);
  assign mgx = mag32(vort_x);
  assign mgy = mag32(vort_y);
  assign mgz = mag32(vort_z);

  assign in_ready  = (state == S_IDLE) && !out_valid;
  assign mctl      = '{start: mstart, busy: (state != S_IDLE)};
  assign eshift    = prod >> EShift;
  assign esum_w    = {1'b0, energy_sum} + {1'b0, eterm};

  // One square of each sum per cycle: x at acceptance, then y, then z.
  always_comb begin
    unique case (sq_phase)
      2'd1:    begin u_op = hy;  g_op = ky;  end
      2'd2:    begin u_op = hz;  g_op = kz;  end
      default: begin u_op = mvx; g_op = mgx; end
    endcase
  end

  assign u_sq = SqW'(u_op) * SqW'(u_op);
  assign g_sq = SqW'(g_op) * SqW'(g_op);

  // Multiplier operands follow the phase of the sequencer.
  always_comb begin
    unique case (state)
      S_SQ:    begin mul_a = SqW'(s_reg); mul_b = CubeW'(s_reg); end
      S_CUBE:  begin mul_a = SqW'(s_reg); mul_b = cube; end
      default: begin mul_a = usq; mul_b = cube; end
    endcase
  end

  pees_sermul u_mul (
    .clk(clk), .rst(rst), .ctl(mctl), .mul_a(mul_a), .mul_b(mul_b),
    .prod(prod), .done(mdone)
  );

  pees_serdiv u_div (
    .clk(clk), .rst(rst), .start(dstart),
    .num(NumW'(gsq) << (FracBits + 32)), .den(cube),
    .quo(dquo), .ovf(dovf), .done(ddone)
  );

  // Sequencer, accumulators and output register.
  always_ff @(posedge clk) begin
    mstart <= 1'b0;
    dstart <= 1'b0;
    if (rst) begin
      state         <= S_IDLE;
      energy_sum    <= '0;
      enstrophy_sum <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && in_ready) begin
          usq      <= u_sq;
          gsq      <= g_sq;
          s_reg    <= core_size;
          last_reg <= last_particle;
          term_sat <= 1'b0;
          mstart   <= 1'b1;
          state    <= S_SQ;
        end
        S_SQ: if (mdone) begin
          cube   <= prod[CubeW-1:0];
          mstart <= 1'b1;
          state  <= S_CUBE;
        end
        S_CUBE: if (mdone) begin
          cube   <= prod[CubeW-1:0];
          mstart <= 1'b1;
          state  <= S_EN;
        end
        S_EN: if (mdone) begin
          if (|eshift[ProdW-1:OutW]) begin
            eterm <= '1; term_sat <= 1'b1;
          end else begin
            eterm <= eshift[OutW-1:0];
          end
          dstart <= (s_reg != '0);
          state  <= S_DIV;
        end
        S_DIV: if (s_reg == '0 || ddone) begin
          state <= S_ACC;
        end
        default: begin
          logic zs, es, zsat, tsat;
          logic [OutW-1:0] zt, ns, nz;
          zsat = (s_reg == '0) || dovf;
          zt   = zsat ? '1 : dquo;
          tsat = term_sat || zsat;
          es   = esum_w[64];
          ns   = es ? '1 : esum_w[63:0];
          {zs, nz} = {1'b0, enstrophy_sum} + {1'b0, zt};
          if (zs) nz = '1;
          if (last_reg) begin
            kinetic_energy <= ns;
            enstrophy      <= nz;
            saturated      <= overflow_seen | tsat | es | zs;
            out_valid      <= 1'b1;
            energy_sum     <= '0;
            enstrophy_sum  <= '0;
            overflow_seen  <= 1'b0;
          end else begin
            energy_sum    <= ns;
            enstrophy_sum <= nz;
            overflow_seen <= overflow_seen | tsat | es | zs;
          end
          state <= S_IDLE;
        end
      endcase
      // The remaining two squares of each sum are folded in one per cycle.
      if (sq_phase != 2'd0) begin
        usq <= usq + u_sq;
        gsq <= gsq + g_sq;
      end
    end
  end

  // Squares of the y and z components, added while s squared is formed.
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_phase <= '0;
    end else if (in_valid && in_ready) begin
      hy <= mvy; hz <= mvz; ky <= mgy; kz <= mgz;
      sq_phase <= 2'd1;
    end else if (sq_phase == 2'd1) begin
      sq_phase <= 2'd2;
    end else if (sq_phase == 2'd2) begin
      sq_phase <= 2'd0;
    end
  end
endmodule

// ===== src/pees_sermul.sv =====
// ----------------------------------------------------------------------------
// pees_sermul
// Shift-and-add multiplier: one multiplier bit per cycle over the 64-bit multiplier.
// ----------------------------------------------------------------------------
module pees_sermul (
  input  logic                       clk,
  input  logic                       rst,
  input  pees_pkg::pees_ctl_t        ctl,
  input  logic [pees_pkg::SqW-1:0]   mul_a,
  input  logic [pees_pkg::CubeW-1:0] mul_b,
  output logic [pees_pkg::ProdW-1:0] prod,
  output logic                       done
);
  import pees_pkg::*;

  logic [SqW-1:0]   a_sh;
  logic [ProdW-1:0] b_sh;
  logic [6:0]       cnt;
  logic             run;

  // Each cycle adds the shifted multiplicand when the low multiplier bit is set.
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (ctl.start) begin
      run  <= 1'b1;
      cnt  <= '0;
      a_sh <= mul_a;
      b_sh <= ProdW'(mul_b);
      prod <= '0;
    end else if (run) begin
      if (a_sh[0]) prod <= prod + b_sh;
      a_sh <= a_sh >> 1;
      b_sh <= b_sh << 1;
      cnt  <= cnt + 7'd1;
      if (cnt == 7'(SqW - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

// ===== src/pees_serdiv.sv =====
// ----------------------------------------------------------------------------
// pees_serdiv
// Restoring divider: one quotient bit per cycle, low bits only kept wide
// enough to detect overflow of the 64-bit result.
// ----------------------------------------------------------------------------
module pees_serdiv (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pees_pkg::NumW-1:0]  num,
  input  logic [pees_pkg::CubeW-1:0] den,
  output logic [pees_pkg::OutW-1:0]  quo,
  output logic                       ovf,
  output logic                       done
);
  import pees_pkg::*;

  logic [NumW-1:0]  n_sh;
  logic [CubeW:0]   rem;
  logic [CubeW:0]   trial;
  logic [7:0]       cnt;
  logic             run;

  assign trial = {rem[CubeW-1:0], n_sh[NumW-1]};

  // Shift in one numerator bit, subtract the divisor when it fits.
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      run  <= 1'b1;
      cnt  <= '0;
      n_sh <= num;
      rem  <= '0;
      quo  <= '0;
      ovf  <= 1'b0;
    end else if (run) begin
      n_sh <= n_sh << 1;
      if (trial >= {1'b0, den}) begin
        rem <= trial - {1'b0, den};
        if (quo[OutW-1]) ovf <= 1'b1;
        quo <= {quo[OutW-2:0], 1'b1};
      end else begin
        rem <= trial;
        if (quo[OutW-1]) ovf <= 1'b1;
        quo <= {quo[OutW-2:0], 1'b0};
      end
      cnt <= cnt + 8'd1;
      if (cnt == 8'(NumW - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

// ===== src/pees_checker.sv =====
// ----------------------------------------------------------------------------
// pees_checker
// Port-level checks of the particle energy core, bound to the top level.
// ----------------------------------------------------------------------------
`include "particle_energy_enstrophy_sum_core_assert.svh"
module pees_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic last_particle,
  input logic out_valid,
  input logic out_ready,
  input logic [63:0] kinetic_energy
);
  `PEES_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `PEES_ASSERT_NXT(a_data_hold, clk, rst, out_valid && !out_ready, $stable(kinetic_energy))
  `PEES_ASSERT_IMP(a_no_in_while_out, clk, rst, out_valid, !in_ready)
  `PEES_ASSERT_NXT(a_busy_after_take, clk, rst, in_valid && in_ready, !in_ready)
  `PEES_ASSERT_NXT(a_no_early_out, clk, rst, in_valid && in_ready && !last_particle, !out_valid)
endmodule

bind particle_energy_enstrophy_sum_core pees_checker u_pees_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .last_particle(last_particle), .out_valid(out_valid), .out_ready(out_ready),
  .kinetic_energy(kinetic_energy)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the particle energy and enstrophy accumulator.
// Sets of vortex particles are sent with random gaps. A scoreboard predicts
// the totals of each set and compares them with every emitted word. The
// stimulus covers extreme fields, zero core sizes, oversized terms and sum
// overflow. The receiver stalls at random and once holds off for a long time.
// ----------------------------------------------------------------------------
module tb_top;
  localparam int Frac     = 16;
  localparam int NumItems = 1000;
  localparam int WdLimit  = 20000;
  localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    bit [31:0] vel[3];
    bit [31:0] vort[3];
    bit [31:0] core;
    bit        last;
  } particle_t;

  typedef struct {
    logic [63:0] energy;
    logic [63:0] enstr;
    logic        sat;
  } totals_t;

  // Predicts the set totals and holds them until the block emits them.
  class energy_scoreboard;
    logic [63:0] energy_acc;
    logic [63:0] enstr_acc;
    logic        flag;
    totals_t     pending[$];
    int          errors;
    int          results;
    int          sat_results;

    function new();
      energy_acc = '0;
      enstr_acc  = '0;
      flag       = 1'b0;
      errors     = 0;
      results    = 0;
      sat_results = 0;
    endfunction

    function logic [191:0] sq_sum(bit [31:0] c[3]);
      logic [191:0] acc;
      logic [31:0]  m;
      acc = '0;
      for (int i = 0; i < 3; i++) begin
        m = c[i][31] ? (~c[i] + 32'd1) : c[i];
        acc += 192'(m) * 192'(m);
      end
      return acc;
    endfunction

    function logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s[64]) begin
        flag = 1'b1;
        return AllOnes;
      end
      return s[63:0];
    endfunction

    // Adds one particle to the totals; a last particle closes the set.
    function void note_particle(particle_t p);
      logic [191:0] cube, wide;
      logic [63:0]  eterm, zterm;
      totals_t      t;
      cube = 192'(p.core) * 192'(p.core) * 192'(p.core);
      wide = (sq_sum(p.vel) * cube) >> (5 * Frac - 31);
      if (wide[191:64] != 0) begin
        eterm = AllOnes;
        flag  = 1'b1;
      end else begin
        eterm = wide[63:0];
      end
      if (p.core == 0) begin
        zterm = AllOnes;
        flag  = 1'b1;
      end else begin
        wide = (sq_sum(p.vort) << (Frac + 32)) / cube;
        if (wide[191:64] != 0) begin
          zterm = AllOnes;
          flag  = 1'b1;
        end else begin
          zterm = wide[63:0];
        end
      end
      energy_acc = add_sat(energy_acc, eterm);
      enstr_acc  = add_sat(enstr_acc, zterm);
      if (p.last) begin
        t.energy = energy_acc;
        t.enstr  = enstr_acc;
        t.sat    = flag;
        pending.push_back(t);
        energy_acc = '0;
        enstr_acc  = '0;
        flag       = 1'b0;
      end
    endfunction

    // Compares an emitted word with the oldest prediction.
    function void check_word(logic [63:0] ke, logic [63:0] en, logic s);
      totals_t t;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result ke=%h en=%h sat=%b", $time, ke, en, s);
        errors++;
        return;
      end
      t = pending.pop_front();
      results++;
      if (t.sat) sat_results++;
      if (ke !== t.energy) begin
        $display("%0t: kinetic_energy expected %h actual %h", $time, t.energy, ke);
        errors++;
      end
      if (en !== t.enstr) begin
        $display("%0t: enstrophy expected %h actual %h", $time, t.enstr, en);
        errors++;
      end
      if (s !== t.sat) begin
        $display("%0t: saturated expected %b actual %b", $time, t.sat, s);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] vel_x = '0, vel_y = '0, vel_z = '0;
  logic [31:0] vort_x = '0, vort_y = '0, vort_z = '0;
  logic [31:0] core_size = '0;
  logic        last_particle = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] kinetic_energy, enstrophy;
  logic        saturated;

  energy_scoreboard sb = new();
  int  sent = 0;
  int  quiet_cycles = 0;
  bit  calm = 1'b0;     // no idling in the last part of the run
  bit  hold_done = 1'b0;

  particle_energy_enstrophy_sum_core dut (.*);

  always #5 clk = ~clk;

  // Watchdog on cycles without any accepted word or taken result.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (!rst) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WdLimit) begin
        $display("%0t: watchdog expired", $time);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Result checking.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_word(kinetic_energy, enstrophy, saturated);
  end

  // Receiver: random stall bursts, one long hold-off, none at the end.
  initial begin
    @(negedge rst);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 18)) @(posedge clk);
      if (!calm) begin
        out_ready <= 1'b0;
        if (!hold_done && sent > 200) begin
          hold_done = 1'b1;
          repeat (1500) @(posedge clk);
        end else if ($urandom_range(0, 2) != 0) begin
          repeat ($urandom_range(1, 18)) @(posedge clk);
        end else begin
          @(posedge clk);
        end
      end
    end
  end

  // Field value with a mix of small, typical, extreme and random values.
  function automatic bit [31:0] pick_field();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($urandom_range(0, 3)) - 32'd1;
      3, 4: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
      default: return $urandom();
    endcase
  endfunction

  function automatic bit [31:0] pick_core();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'($urandom_range(1, 4));
      3, 4, 5: return 32'($urandom_range(32'h0000_4000, 32'h0004_0000));
      default: return $urandom();
    endcase
  endfunction

  // Offers one particle and waits for it to be accepted.
  task automatic send_particle(particle_t p);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    {vel_x, vel_y, vel_z}    <= {p.vel[0], p.vel[1], p.vel[2]};
    {vort_x, vort_y, vort_z} <= {p.vort[0], p.vort[1], p.vort[2]};
    core_size     <= p.core;
    last_particle <= p.last;
    in_valid      <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_particle(p);
    sent++;
  endtask

  task automatic send_fields(bit [31:0] v, bit [31:0] g, bit [31:0] s, bit last);
    particle_t p;
    p.vel  = '{v, v, v};
    p.vort = '{g, g, g};
    p.core = s;
    p.last = last;
    send_particle(p);
  endtask

  initial begin
    particle_t p;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zeros, unit values, extremes, zero core, tiny and huge cores.
    send_fields(32'h0, 32'h0, 32'h0001_0000, 1'b1);
    send_fields(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1);
    send_fields(32'hFFFF_0000, 32'hFFFF_0000, 32'h0001_0000, 1'b1);
    send_fields(32'h8000_0000, 32'h8000_0000, 32'h0001_0000, 1'b1);
    send_fields(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
    send_fields(32'h0003_0000, 32'h0002_0000, 32'h0, 1'b1);
    send_fields(32'h0, 32'h0001_0000, 32'h1, 1'b1);
    send_fields(32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1);
    send_fields(32'h0001_8000, 32'hFFFE_8000, 32'h0000_8000, 1'b0);
    send_fields(32'h0000_4000, 32'h0003_0000, 32'h0002_0000, 1'b1);
    // Three oversized energy terms in one set, then a plain set after the clear.
    send_fields(32'h0100_0000, 32'h0, 32'h0100_0000, 1'b0);
    send_fields(32'h0100_0000, 32'h0, 32'h0100_0000, 1'b0);
    send_fields(32'h0100_0000, 32'h0, 32'h0100_0000, 1'b1);
    send_fields(32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 1'b1);

    // Random sets; each particle closes its set with a chance of one in four.
    while (sent < NumItems) begin
      if (sent > NumItems - 100) calm = 1'b1;
      for (int i = 0; i < 3; i++) begin
        p.vel[i]  = pick_field();
        p.vort[i] = pick_field();
      end
      p.core = pick_core();
      p.last = ($urandom_range(0, 3) == 0) || (sent == NumItems - 1);
      send_particle(p);
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("Sent %0d particles; checked %0d set totals, %0d of them saturated.",
             sent, sb.results, sb.sat_results);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
